/* rtl/ffha_pkg.sv */
// Shared definitions for the first-fit heap allocator: opcodes, port widths and result status values.
package ffha_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam int ADDR_W   = 20;
    localparam int BYTES_W  = 21;
    localparam int STATUS_W = 3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t STATUS_OK      = 3'd0;
    localparam status_t STATUS_IGNORED = 3'd1;
    localparam status_t STATUS_NOMEM   = 3'd2;
    localparam status_t STATUS_FULL    = 3'd3;
    localparam status_t STATUS_BADFREE = 3'd4;

endpackage

/* rtl/ffha_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/first_fit_heap_allocator_core.sv */
// Top level of the first-fit heap allocator: request sequencer around the segment table RAM.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  request | s_valid s_ready s_opcode s_alloc_bytes s_free_address | in
//  result  | m_valid m_ready m_payload_address m_status          | out
//
// One request is in flight at a time. A request scans the segment table in
// address order, reading each entry from the RAM and then checking it; the
// table sits behind a single RAM port pair. A split moves every later entry
// up one slot and a merging free moves them down by one or two, one entry at
// a time, each with a RAM read and then a write.
// After reset the block writes the initial free segment into entry 0 and
// takes no request until that write is done.
// A stalled result sits in the output register; the next request is taken
// meanwhile, and its own result waits until the register is empty.
module first_fit_heap_allocator_core #(
    parameter int ARENA_BYTES   = 1048576,
    parameter int GRANULE_BYTES = 32,
    parameter int MAX_SEGMENTS  = 256
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_opcode,
    input  logic [ffha_pkg::BYTES_W-1:0] s_alloc_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0]  s_free_address,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ffha_pkg::ADDR_W-1:0]  m_payload_address,
    output logic [ffha_pkg::STATUS_W-1:0] m_status
);
    import ffha_pkg::*;

    // granule geometry (granule size is a power of two)
    localparam int TOTAL_GRAN = ARENA_BYTES / GRANULE_BYTES;
    localparam int GW         = $clog2(TOTAL_GRAN);
    localparam int GSH        = $clog2(GRANULE_BYTES);
    localparam int NW         = BYTES_W + 1;
    localparam int PW         = GW + 1 + GSH;
    localparam int CW_ADDR    = (PW > ADDR_W) ? PW : ADDR_W;
    localparam int CW         = $clog2(MAX_SEGMENTS + 1);
    localparam int IW         = $clog2(MAX_SEGMENTS);

    typedef struct packed {
        logic [GW-1:0] start;
        logic [GW-1:0] size;
        logic          used;
    } seg_t;

    localparam int SEG_W = $bits(seg_t);

    // sequencer states
    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_UPRD   = 4'd4;
    localparam logic [3:0] S_UPWR   = 4'd5;
    localparam logic [3:0] S_SPLIT1 = 4'd6;
    localparam logic [3:0] S_SPLIT2 = 4'd7;
    localparam logic [3:0] S_NXRD   = 4'd8;
    localparam logic [3:0] S_FREEW  = 4'd9;
    localparam logic [3:0] S_DNRD   = 4'd10;
    localparam logic [3:0] S_DNWR   = 4'd11;
    localparam logic [3:0] S_RESP   = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     hit_reg, hit_next;
    logic [CW-1:0]     ptr_reg, ptr_next;
    logic [1:0]        gap_reg, gap_next;
    logic              op_reg, op_next;
    logic [NW-1:0]     need_reg, need_next;
    logic [ADDR_W-1:0] faddr_reg, faddr_next;
    logic              nxt_ok_reg, nxt_ok_next;
    seg_t              cur_reg, cur_next;
    seg_t              prev_reg, prev_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    status_t           res_status_reg, res_status_next;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    status_t           m_status_reg, m_status_next;

    logic              mem_we;
    logic [IW-1:0]     mem_waddr, mem_raddr;
    seg_t              mem_wdata, mem_rdata;
    logic [SEG_W-1:0]  rdata_raw;

    ffha_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS)) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata_raw)
    );
    assign mem_rdata = seg_t'(rdata_raw);

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_payload_address = m_addr_reg;
    assign m_status          = m_status_reg;

    logic [NW-1:0]      size_ext;
    logic [CW_ADDR-1:0] seg_payload, faddr_ext;
    logic [PW-1:0]      payload_full;
    logic [CW-1:0]      idx_inc, ptr_dst;
    logic               pfree, nfree;
    logic [GW:0]        merged;
    logic [1:0]         gap_w;

    always_comb begin
        size_ext     = {{(NW-GW){1'b0}}, mem_rdata.size};
        payload_full = PW'({1'b0, mem_rdata.start} + (GW+1)'(1)) << GSH;
        seg_payload  = CW_ADDR'(payload_full);
        faddr_ext    = CW_ADDR'(faddr_reg);
        idx_inc      = idx_reg + CW'(1);
        pfree        = (hit_reg != '0) && !prev_reg.used;
        nfree        = nxt_ok_reg && !mem_rdata.used;
        merged       = '0;
        gap_w        = '0;
        ptr_dst      = '0;

        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        ptr_next        = ptr_reg;
        gap_next        = gap_reg;
        op_next         = op_reg;
        need_next       = need_reg;
        faddr_next      = faddr_reg;
        nxt_ok_next     = nxt_ok_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_addr_next     = m_addr_reg;
        m_status_next   = m_status_reg;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;

        // drop the result once the consumer takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                // seed the single free segment covering the arena
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.start = '0;
                mem_wdata.size  = GW'(TOTAL_GRAN - 1);
                mem_wdata.used  = 1'b0;
                state_next      = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = s_opcode;
                    need_next     = (NW'(s_alloc_bytes) + NW'(GRANULE_BYTES - 1)) >> GSH;
                    faddr_next    = s_free_address;
                    idx_next      = '0;
                    res_addr_next = '0;
                    if ((s_opcode == OP_ALLOC && s_alloc_bytes == '0) ||
                        (s_opcode == OP_FREE && s_free_address == '0)) begin
                        res_status_next = STATUS_IGNORED;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                if (idx_reg >= count_reg) begin
                    res_status_next = (op_reg == OP_ALLOC) ? STATUS_NOMEM : STATUS_BADFREE;
                    state_next      = S_RESP;
                end else begin
                    mem_raddr  = idx_reg[IW-1:0];
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                prev_next  = mem_rdata;
                idx_next   = idx_inc;
                state_next = S_RD;
                if (op_reg == OP_ALLOC) begin
                    if (!mem_rdata.used && size_ext == need_reg) begin
                        // exact fit: mark used in place
                        mem_we          = 1'b1;
                        mem_waddr       = idx_reg[IW-1:0];
                        mem_wdata       = mem_rdata;
                        mem_wdata.used  = 1'b1;
                        res_addr_next   = seg_payload[ADDR_W-1:0];
                        res_status_next = STATUS_OK;
                        state_next      = S_RESP;
                    end else if (!mem_rdata.used && size_ext > need_reg) begin
                        if (count_reg >= CW'(MAX_SEGMENTS)) begin
                            res_status_next = STATUS_FULL;
                            state_next      = S_RESP;
                        end else begin
                            cur_next = mem_rdata;
                            hit_next = idx_reg;
                            ptr_next = count_reg - CW'(1);
                            res_addr_next = seg_payload[ADDR_W-1:0];
                            state_next = (count_reg > idx_inc) ? S_UPRD : S_SPLIT1;
                        end
                    end
                end else begin
                    if (mem_rdata.used && seg_payload == faddr_ext) begin
                        cur_next    = mem_rdata;
                        hit_next    = idx_reg;
                        prev_next   = prev_reg;
                        nxt_ok_next = (idx_inc < count_reg);
                        state_next  = (idx_inc < count_reg) ? S_NXRD : S_FREEW;
                    end
                end
            end
            S_UPRD: begin
                mem_raddr  = ptr_reg[IW-1:0];
                state_next = S_UPWR;
            end
            S_UPWR: begin
                // move entry up one slot to open a hole after the split segment
                mem_we    = 1'b1;
                mem_waddr = IW'(ptr_reg + CW'(1));
                mem_wdata = mem_rdata;
                if ((ptr_reg - CW'(1)) > hit_reg) begin
                    ptr_next   = ptr_reg - CW'(1);
                    state_next = S_UPRD;
                end else begin
                    state_next = S_SPLIT1;
                end
            end
            S_SPLIT1: begin
                mem_we          = 1'b1;
                mem_waddr       = IW'(hit_reg + CW'(1));
                mem_wdata.start = GW'({1'b0, cur_reg.start} + (GW+1)'(need_reg) + (GW+1)'(1));
                mem_wdata.size  = GW'(cur_reg.size - GW'(need_reg) - GW'(1));
                mem_wdata.used  = 1'b0;
                state_next      = S_SPLIT2;
            end
            S_SPLIT2: begin
                mem_we          = 1'b1;
                mem_waddr       = hit_reg[IW-1:0];
                mem_wdata.start = cur_reg.start;
                mem_wdata.size  = GW'(need_reg);
                mem_wdata.used  = 1'b1;
                count_next      = count_reg + CW'(1);
                res_status_next = STATUS_OK;
                state_next      = S_RESP;
            end
            S_NXRD: begin
                mem_raddr  = IW'(hit_reg + CW'(1));
                state_next = S_FREEW;
            end
            S_FREEW: begin
                // merge with free neighbors; mem_rdata holds the next entry if any
                mem_we          = 1'b1;
                mem_wdata.used  = 1'b0;
                res_status_next = STATUS_OK;
                if (pfree) begin
                    merged = {1'b0, prev_reg.size} + {1'b0, cur_reg.size} + (GW+1)'(1);
                    if (nfree) begin
                        merged = merged + {1'b0, mem_rdata.size} + (GW+1)'(1);
                    end
                    mem_waddr       = IW'(hit_reg - CW'(1));
                    mem_wdata.start = prev_reg.start;
                    mem_wdata.size  = merged[GW-1:0];
                    gap_w           = nfree ? 2'd2 : 2'd1;
                    ptr_dst         = hit_reg;
                end else begin
                    merged = {1'b0, cur_reg.size};
                    if (nfree) begin
                        merged = merged + {1'b0, mem_rdata.size} + (GW+1)'(1);
                    end
                    mem_waddr       = hit_reg[IW-1:0];
                    mem_wdata.start = cur_reg.start;
                    mem_wdata.size  = merged[GW-1:0];
                    gap_w           = nfree ? 2'd1 : 2'd0;
                    ptr_dst         = hit_reg + CW'(1);
                end
                gap_next   = gap_w;
                ptr_next   = ptr_dst + CW'(gap_w);
                state_next = (gap_w == 2'd0) ? S_RESP : S_DNRD;
            end
            S_DNRD: begin
                if (ptr_reg >= count_reg) begin
                    count_next = count_reg - CW'(gap_reg);
                    state_next = S_RESP;
                end else begin
                    mem_raddr  = ptr_reg[IW-1:0];
                    state_next = S_DNWR;
                end
            end
            S_DNWR: begin
                // close the hole left by merged entries
                mem_we     = 1'b1;
                mem_waddr  = IW'(ptr_reg - CW'(gap_reg));
                mem_wdata  = mem_rdata;
                ptr_next   = ptr_reg + CW'(1);
                state_next = S_DNRD;
            end
            S_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            count_reg   <= CW'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        ptr_reg        <= ptr_next;
        gap_reg        <= gap_next;
        op_reg         <= op_next;
        need_reg       <= need_next;
        faddr_reg      <= faddr_next;
        nxt_ok_reg     <= nxt_ok_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_addr_reg     <= m_addr_next;
        m_status_reg   <= m_status_next;
    end

endmodule
